// ===== src/aad_pkg.sv =====
// ----------------------------------------------------------------------------
// aad_pkg
// Shared types, constants and the premultiply function for the area-average downscaler.
// ----------------------------------------------------------------------------
package aad_pkg;

   localparam int NUM_CH   = 4;
   localparam int CH_W     = 8;
   localparam int QUO_W    = 9;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 8'd3;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_ADD  = 4'b0100,
      S_DIV  = 4'b1000
   } state_type;

   // Rounded (c * a) / 255 without a divider; exact for all products up to 65025 (255 * 255).
   function automatic logic [CH_W-1:0] premul(input logic [CH_W-1:0] c,
                                              input logic [CH_W-1:0] a);
      logic [16:0] t;
      logic [16:0] s;
      t = 17'(c * a) + 17'd128;
      s = t + (t >> 8);
      return s[15:8];
   endfunction

endpackage

// ===== src/aad_divider.sv =====
// ----------------------------------------------------------------------------
// aad_divider
// Four-lane restoring divider: computes (2*sum + W) / (2*W), one quotient
// bit per cycle, saturated to 255.
// ----------------------------------------------------------------------------
module aad_divider
   import aad_pkg::*;
#(
   parameter int ACC_W = 25,
   parameter int WS_W  = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_CH-1:0][ACC_W-1:0]  sums,
   input  logic [WS_W-1:0]               wsum,
   input  logic                          take,
   output logic                          res_valid,
   output logic [NUM_CH-1:0][CH_W-1:0]   quotient
);
   localparam int N_W   = ACC_W + 2;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [NUM_CH-1:0][N_W-1:0]   rem_ff, rem_in;
   logic [NUM_CH-1:0][QUO_W-1:0] quo_ff, quo_in;
   logic [N_W-1:0]               div_ff, div_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff && !take;
      if (start) begin
         for (int i = 0; i < NUM_CH; i++) begin
            rem_in[i] = (N_W'(sums[i]) << 1) + N_W'(wsum);
            quo_in[i] = '0;
         end
         div_in  = N_W'(wsum) << QUO_W;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         for (int i = 0; i < NUM_CH; i++) begin
            if (rem_ff[i] >= div_ff) begin
               rem_in[i] = rem_ff[i] - div_ff;
               quo_in[i] = {quo_ff[i][QUO_W-2:0], 1'b1};
            end else begin
               quo_in[i] = {quo_ff[i][QUO_W-2:0], 1'b0};
            end
         end
         div_in = div_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign res_valid = done_ff;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         quotient[i] = quo_ff[i][QUO_W-1] ? {CH_W{1'b1}} : quo_ff[i][CH_W-1:0];
      end
   end

endmodule

// ===== src/area_average_downscaler_core.sv =====
// ----------------------------------------------------------------------------
// area_average_downscaler_core
// Streams source ARGB pixels, premultiplies them and accumulates area
// weighted sums per destination pixel in a row-bank memory; finished pixels
// are averaged by a serial divider and sent out.
// ----------------------------------------------------------------------------
// Each source pixel is accepted in the idle state, then takes a read and an add
// state per touched destination pixel (one to four) for the read-modify-write
// of the accumulator memory. A pixel that completes a destination pixel then
// waits in the divide state for nine quotient steps and one hand-off before
// the result lands in the output register, longer while that register stalls.
// Synchronous reset clears all accumulators at once through per-entry valid
// bits; a write to a known size register restarts the frame in the same way.
module area_average_downscaler_core
   import aad_pkg::*;
#(
   parameter int MAX_SRC_W = 256,
   parameter int MAX_SRC_H = 256,
   parameter int MAX_DST_W = 128,
   parameter int MAX_DST_H = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // in_pixel[31:0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // out_pixel[31:0], out_col[38:32],
                                             // out_row[45:39], zero fill
   output logic                 rsp_tlast,   // frame_last
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);
   localparam int SW_W  = $clog2(MAX_SRC_W + 1);
   localparam int SH_W  = $clog2(MAX_SRC_H + 1);
   localparam int DW_W  = $clog2(MAX_DST_W + 1);
   localparam int DH_W  = $clog2(MAX_DST_H + 1);
   localparam int XC_W  = $clog2(MAX_DST_W);
   localparam int YC_W  = $clog2(MAX_DST_H);
   localparam int WS_W  = $clog2(MAX_SRC_W * MAX_SRC_H + 1);
   localparam int ACC_W = WS_W + CH_W;
   localparam int DEPTH = 2 * MAX_DST_W;
   localparam int AW    = $clog2(DEPTH);
   localparam int WT_W  = DW_W + DH_W;
   localparam int MEM_W = NUM_CH * ACC_W;

   // Configuration registers.
   logic [8:0] src_width_ff, src_height_ff;
   logic [7:0] dst_width_ff, dst_height_ff;

   logic [SW_W-1:0] sw;
   logic [SH_W-1:0] sh;
   logic [DW_W-1:0] dw;
   logic [DH_W-1:0] dh;
   logic [WS_W-1:0] wsum_ff;

   always_comb begin
      sw = (src_width_ff == '0) ? SW_W'(1) :
           (32'(src_width_ff) > 32'(MAX_SRC_W)) ? SW_W'(MAX_SRC_W) : SW_W'(src_width_ff);
      sh = (src_height_ff == '0) ? SH_W'(1) :
           (32'(src_height_ff) > 32'(MAX_SRC_H)) ? SH_W'(MAX_SRC_H) : SH_W'(src_height_ff);
      dw = (dst_width_ff == '0) ? DW_W'(1) :
           (32'(dst_width_ff) > 32'(MAX_DST_W)) ? DW_W'(MAX_DST_W) : DW_W'(dst_width_ff);
      dh = (dst_height_ff == '0) ? DH_W'(1) :
           (32'(dst_height_ff) > 32'(MAX_DST_H)) ? DH_W'(MAX_DST_H) : DH_W'(dst_height_ff);
      if (32'(dw) > 32'(sw)) dw = DW_W'(sw);
      if (32'(dh) > 32'(sh)) dh = DH_W'(sh);
   end

   logic csr_fire;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      wsum_ff <= WS_W'(sw * sh);
      if (reset) begin
         src_width_ff  <= 9'd128;
         src_height_ff <= 9'd128;
         dst_width_ff  <= 8'd72;
         dst_height_ff <= 8'd72;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
            CSR_SRC_HEIGHT: src_height_ff <= csr_data;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data[7:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   logic csr_known;
   assign csr_known = (csr_index == CSR_SRC_WIDTH) || (csr_index == CSR_SRC_HEIGHT) ||
                      (csr_index == CSR_DST_WIDTH) || (csr_index == CSR_DST_HEIGHT);

   // Source position, kept as destination column/row plus remainder.
   logic [SW_W-1:0] sx_ff, xrem_ff;
   logic [SH_W-1:0] sy_ff, yrem_ff;
   logic [XC_W-1:0] xcol_ff;
   logic [YC_W-1:0] ycol_ff;

   state_type state_ff, state_in;
   logic req_fire;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   logic [SW_W:0] xsum;
   logic [SH_W:0] ysum;
   logic          row_end, frame_end;
   assign xsum      = (SW_W+1)'(xrem_ff) + (SW_W+1)'(dw);
   assign ysum      = (SH_W+1)'(yrem_ff) + (SH_W+1)'(dh);
   assign row_end   = (sx_ff + 1'b1) == sw;
   assign frame_end = (sy_ff + 1'b1) == sh;

   always_ff @(posedge clock) begin
      if (reset || (csr_fire && csr_known)) begin
         sx_ff   <= '0;
         xrem_ff <= '0;
         xcol_ff <= '0;
         sy_ff   <= '0;
         yrem_ff <= '0;
         ycol_ff <= '0;
      end else if (req_fire) begin
         if (row_end) begin
            sx_ff   <= '0;
            xrem_ff <= '0;
            xcol_ff <= '0;
            if (frame_end) begin
               sy_ff   <= '0;
               yrem_ff <= '0;
               ycol_ff <= '0;
            end else begin
               sy_ff <= sy_ff + 1'b1;
               if (ysum >= (SH_W+1)'(sh)) begin
                  yrem_ff <= SH_W'(ysum - (SH_W+1)'(sh));
                  ycol_ff <= ycol_ff + 1'b1;
               end else begin
                  yrem_ff <= SH_W'(ysum);
               end
            end
         end else begin
            sx_ff <= sx_ff + 1'b1;
            if (xsum >= (SW_W+1)'(sw)) begin
               xrem_ff <= SW_W'(xsum - (SW_W+1)'(sw));
               xcol_ff <= xcol_ff + 1'b1;
            end else begin
               xrem_ff <= SW_W'(xsum);
            end
         end
      end
   end

   // Per-pixel work registers.
   logic [NUM_CH-1:0][CH_W-1:0] ch_ff;
   logic [XC_W-1:0] x0_ff;
   logic [YC_W-1:0] y0_ff;
   logic            two_x_ff, two_y_ff, emit_ff, last_ff;
   logic [DW_W-1:0] wx0_ff, wx1_ff;
   logic [DH_W-1:0] wy0_ff, wy1_ff;
   logic [1:0]      k_ff;
   logic [WT_W-1:0] w_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff[3] <= req_tdata[31:24];
         ch_ff[2] <= premul(req_tdata[23:16], req_tdata[31:24]);
         ch_ff[1] <= premul(req_tdata[15:8], req_tdata[31:24]);
         ch_ff[0] <= premul(req_tdata[7:0], req_tdata[31:24]);
         x0_ff    <= xcol_ff;
         y0_ff    <= ycol_ff;
         two_x_ff <= xsum > (SW_W+1)'(sw);
         two_y_ff <= ysum > (SH_W+1)'(sh);
         emit_ff  <= (xsum == (SW_W+1)'(sw)) && (ysum == (SH_W+1)'(sh));
         last_ff  <= ((DW_W+1)'(xcol_ff) + 1'b1 == (DW_W+1)'(dw)) &&
                     ((DH_W+1)'(ycol_ff) + 1'b1 == (DH_W+1)'(dh));
         wx0_ff   <= (xsum > (SW_W+1)'(sw)) ? DW_W'(sw - xrem_ff) : dw;
         wx1_ff   <= DW_W'(xsum - (SW_W+1)'(sw));
         wy0_ff   <= (ysum > (SH_W+1)'(sh)) ? DH_W'(sh - yrem_ff) : dh;
         wy1_ff   <= DH_W'(ysum - (SH_W+1)'(sh));
      end
      if (state_ff == S_READ) begin
         w_ff <= WT_W'((k_ff[0] ? wx1_ff : wx0_ff) * (k_ff[1] ? wy1_ff : wy0_ff));
      end
   end

   // Accumulator memory with per-entry valid bits; an invalid entry reads zero.
   logic [MEM_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [MEM_W-1:0] rd_data_ff;
   logic             rd_vld_ff;
   logic [XC_W-1:0]  tx;
   logic [YC_W-1:0]  ty;
   logic [AW-1:0]    addr_ff;
   logic [AW-1:0]    addr;

   assign tx   = x0_ff + XC_W'(k_ff[0]);
   assign ty   = y0_ff + YC_W'(k_ff[1]);
   assign addr = AW'(tx) + (ty[0] ? AW'(MAX_DST_W) : AW'(0));

   // Entries that are never emitted keep growing across rows and frames, so
   // the sum saturates; a saturated sum still averages to 255.
   logic [NUM_CH-1:0][ACC_W-1:0] acc_sum;
   always_comb begin
      logic [ACC_W:0] acc_wide;
      for (int i = 0; i < NUM_CH; i++) begin
         acc_wide = (ACC_W+1)'(rd_vld_ff ? rd_data_ff[i*ACC_W +: ACC_W] : ACC_W'(0)) +
                    (ACC_W+1)'(w_ff * ch_ff[i]);
         acc_sum[i] = acc_wide[ACC_W] ? {ACC_W{1'b1}} : acc_wide[ACC_W-1:0];
      end
   end

   logic        k_more;
   logic [1:0]  k_next;
   always_comb begin
      k_more = 1'b1;
      k_next = k_ff;
      if (two_x_ff && !k_ff[0]) begin
         k_next = {k_ff[1], 1'b1};
      end else if (two_y_ff && !k_ff[1]) begin
         k_next = 2'b10;
      end else begin
         k_more = 1'b0;
      end
   end

   logic div_start, div_valid, div_take;
   logic [NUM_CH-1:0][CH_W-1:0] div_q;
   logic rsp_free;

   assign div_start = (state_ff == S_ADD) && emit_ff;
   assign rsp_free  = !rsp_tvalid || rsp_tready;
   assign div_take  = (state_ff == S_DIV) && div_valid && rsp_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_READ;
         S_READ:  state_in = S_ADD;
         S_ADD:   state_in = emit_ff ? S_DIV : (k_more ? S_READ : S_IDLE);
         S_DIV:   if (div_take) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire) k_ff <= '0;
         else if (state_ff == S_ADD && k_more) k_ff <= k_next;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_data_ff <= mem[addr];
         rd_vld_ff  <= vld_ff[addr];
         addr_ff    <= addr;
      end
      if (state_ff == S_ADD && !emit_ff) begin
         mem[addr_ff] <= acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_fire && csr_known)) begin
         vld_ff <= '0;
      end else if (state_ff == S_ADD) begin
         // An emitted entry is retired by dropping its valid bit.
         vld_ff[addr_ff] <= !emit_ff;
      end
   end

   aad_divider #(
      .ACC_W (ACC_W),
      .WS_W  (WS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .sums      (acc_sum),
      .wsum      (wsum_ff),
      .take      (div_take),
      .res_valid (div_valid),
      .quotient  (div_q)
   );

   // Output register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_pixel_ff;
   logic [6:0]  rsp_col_ff, rsp_row_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (div_take) begin
         rsp_pixel_ff <= {div_q[3], div_q[2], div_q[1], div_q[0]};
         rsp_col_ff   <= 7'(x0_ff);
         rsp_row_ff   <= 7'(y0_ff);
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_row_ff, rsp_col_ff, rsp_pixel_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_READ)
      else $error("accepted pixel did not start a memory read");

   a_out_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DIV)
      else $error("result loaded outside divide state");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && csr_known) |=> vld_ff == '0)
      else $error("configuration write did not clear accumulators");

   a_single_target_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && emit_ff) |-> (k_ff == 2'b00 && !two_x_ff && !two_y_ff))
      else $error("emit on a pixel that spans several destinations");
`endif

endmodule

// ===== tb/tb_area_average_downscaler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_area_average_downscaler_core
// Self-checking bench for the area-average downscaler. Source pixels come
// from a queue. The bench's own copy of the size registers and of the row
// accumulators predicts every averaged pixel. Results are checked in order.
// ----------------------------------------------------------------------------
module tb_area_average_downscaler_core
   import aad_pkg::*;
();

   localparam int DST_COLS = 128;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [31:0] pixel;
      logic [6:0]  col;
      logic [6:0]  row;
      logic        last;
   } avg_pixel_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [47:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   area_average_downscaler_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [31:0]       pixel_queue[$];
   avg_pixel_t        expected_pixels[$];
   int                pushed_count = 0;
   int                accepted_count = 0;
   int                error_count = 0;
   bit                quiet = 1'b0;

   // Predictor state: size registers, raster position, two row banks.
   logic [8:0]        src_w_reg, src_h_reg;
   logic [7:0]        dst_w_reg, dst_h_reg;
   int unsigned       src_col, src_row;
   longint unsigned   sum_a[2*DST_COLS], sum_r[2*DST_COLS];
   longint unsigned   sum_g[2*DST_COLS], sum_b[2*DST_COLS];

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint unsigned span_overlap(longint unsigned s, longint unsigned d,
                                                    longint unsigned t, longint unsigned sz);
      longint unsigned lo, hi;
      lo = s * d;
      hi = (s + 1) * d;
      if (t * sz > lo) lo = t * sz;
      if ((t + 1) * sz < hi) hi = (t + 1) * sz;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic logic [7:0] round_average(longint unsigned sum, longint unsigned w);
      longint unsigned v;
      v = (2 * sum + w) / (2 * w);
      return (v > 255) ? 8'hff : v[7:0];
   endfunction

   task automatic restart_frame();
      src_col = 0;
      src_row = 0;
      for (int i = 0; i < 2*DST_COLS; i++) begin
         sum_a[i] = 0; sum_r[i] = 0; sum_g[i] = 0; sum_b[i] = 0;
      end
   endtask

   task automatic predict_pixel(input logic [31:0] px);
      int unsigned     sw, sh, dw, dh, a, idx;
      int unsigned     ch[4];
      longint unsigned sx, sy, x0, x1, y0, y1, wy, w, wsum;
      avg_pixel_t      res;
      sw = clamp_size(src_w_reg, 256);
      sh = clamp_size(src_h_reg, 256);
      dw = clamp_size(dst_w_reg, 128);
      dh = clamp_size(dst_h_reg, 128);
      if (dw > sw) dw = sw;
      if (dh > sh) dh = sh;
      if (src_col >= sw || src_row >= sh) begin
         src_col = 0;
         src_row = 0;
      end
      sx = src_col;
      sy = src_row;
      a = px[31:24];
      ch[0] = a;
      ch[1] = (px[23:16] * a + 127) / 255;
      ch[2] = (px[15:8] * a + 127) / 255;
      ch[3] = (px[7:0] * a + 127) / 255;
      x0 = sx * dw / sw;
      x1 = ((sx + 1) * dw - 1) / sw;
      y0 = sy * dh / sh;
      y1 = ((sy + 1) * dh - 1) / sh;
      for (longint unsigned yy = y0; yy <= y1; yy++) begin
         wy = span_overlap(sy, dh, yy, sh);
         for (longint unsigned xx = x0; xx <= x1; xx++) begin
            w = wy * span_overlap(sx, dw, xx, sw);
            if (w != 0 && xx < DST_COLS) begin
               idx = yy[0] * DST_COLS + xx;
               sum_a[idx] += w * ch[0];
               sum_r[idx] += w * ch[1];
               sum_g[idx] += w * ch[2];
               sum_b[idx] += w * ch[3];
            end
         end
      end
      // The destination pixel is complete once this source pixel reaches its
      // right and bottom edges.
      if ((x1 + 1) * sw <= (sx + 1) * dw && (y1 + 1) * sh <= (sy + 1) * dh &&
          x1 < DST_COLS) begin
         idx = y1[0] * DST_COLS + x1;
         wsum = longint'(sw) * sh;
         res.pixel = {round_average(sum_a[idx], wsum), round_average(sum_r[idx], wsum),
                      round_average(sum_g[idx], wsum), round_average(sum_b[idx], wsum)};
         res.col = x1[6:0];
         res.row = y1[6:0];
         res.last = (x1 + 1 == dw && y1 + 1 == dh);
         expected_pixels.push_back(res);
         sum_a[idx] = 0; sum_r[idx] = 0; sum_g[idx] = 0; sum_b[idx] = 0;
      end
      src_col++;
      if (src_col >= sw) begin
         src_col = 0;
         src_row++;
         if (src_row >= sh) src_row = 0;
      end
   endtask

   // Source pixel driver.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata);
            accepted_count++;
         end
         if (req_tvalid && !req_tready) begin
            // Hold the current transaction.
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 17);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= pixel_queue.pop_front();
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor with random back-pressure.
   int stall_left = 0;
   always @(posedge clock) begin
      avg_pixel_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result pixel %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata[31:0] !== want.pixel) begin
                  $error("out_pixel expected %h actual %h", want.pixel, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[38:32] !== want.col) begin
                  $error("out_col expected %0d actual %0d", want.col, rsp_tdata[38:32]);
                  error_count++;
               end
               if (rsp_tdata[45:39] !== want.row) begin
                  $error("out_row expected %0d actual %0d", want.row, rsp_tdata[45:39]);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("frame_last expected %0b actual %0b", want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      while (accepted_count != pushed_count || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SRC_WIDTH:  begin src_w_reg = val;      restart_frame(); end
         CSR_SRC_HEIGHT: begin src_h_reg = val;      restart_frame(); end
         CSR_DST_WIDTH:  begin dst_w_reg = val[7:0]; restart_frame(); end
         CSR_DST_HEIGHT: begin dst_h_reg = val[7:0]; restart_frame(); end
         default: ;
      endcase
   endtask

   task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
      wait_idle();
      write_csr(CSR_SRC_WIDTH, sw);
      write_csr(CSR_SRC_HEIGHT, sh);
      write_csr(CSR_DST_WIDTH, dw);
      write_csr(CSR_DST_HEIGHT, dh);
      if ($urandom_range(0, 5) == 0) write_csr($urandom_range(4, 255), $urandom);
   endtask

   task automatic push_pixel(input logic [31:0] px);
      pixel_queue.push_back(px);
      pushed_count++;
   endtask

   function automatic logic [31:0] random_pixel();
      logic [31:0] px;
      px = $urandom;
      case ($urandom_range(0, 5))
         0: px[31:24] = 8'h00;
         1: px[31:24] = 8'hff;
         default: ;
      endcase
      return px;
   endfunction

   initial begin
      int sw, sh, dw, dh, count;
      src_w_reg = 9'd128;
      src_h_reg = 9'd128;
      dst_w_reg = 8'd72;
      dst_h_reg = 8'd72;
      restart_frame();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes: a few pixels, no result is due yet.
      push_pixel(32'h0000_0000);
      push_pixel(32'hffff_ffff);
      push_pixel(32'hff00_0000);
      push_pixel(32'h00ff_ffff);

      // Zero sizes read as one: every pixel is its own result.
      set_sizes(0, 0, 0, 0);
      push_pixel(32'hffff_ffff);
      push_pixel(32'h80ff_ff00);
      push_pixel(32'h0112_3456);
      push_pixel(32'hfe80_7f01);
      push_pixel(32'h0000_0000);

      // Oversized source saturates, result width clamps, zero height reads as one.
      set_sizes(9'h1ff, 2, 9'h1ff, 0);
      for (int i = 0; i < 512; i++) push_pixel(random_pixel());

      // Odd ratio with a frame wrap.
      set_sizes(3, 3, 2, 2);
      for (int i = 0; i < 12; i++) push_pixel(random_pixel());

      while (pushed_count < 1500) begin
         if (pushed_count > 1250) quiet = 1'b1;
         sw = $urandom_range(1, 20);
         sh = $urandom_range(1, 12);
         dw = $urandom_range(0, sw + 3);
         dh = $urandom_range(0, sh + 3);
         if ($urandom_range(0, 7) == 0) dw |= 9'h100;
         if ($urandom_range(0, 7) == 0) dh |= 9'h100;
         set_sizes(sw, sh, dw, dh);
         count = sw * sh * $urandom_range(1, 2);
         // Now and then a frame is cut short by the next register write.
         if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
         for (int i = 0; i < count; i++) push_pixel(random_pixel());
      end

      wait_idle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/aad_pkg.sv
src/aad_divider.sv
src/area_average_downscaler_core.sv
tb/tb_area_average_downscaler_core.sv
